// ===== rtl/pdwb_pkg.sv =====
// Package for the PLL divider word builder: shared types, field limits,
// register indexes and word address codes. No dependencies.

package pdwb_pkg;

  // Output word width and field limits
  localparam int WORD_BITS  = 24;
  localparam int DIVD_BITS  = 32;
  localparam int DIVS_BITS  = 27;
  localparam int CNT_BITS   = 6;
  localparam int R_BITS     = 14;
  localparam int B_BITS     = 13;
  localparam int A_BITS     = 6;

  localparam logic [DIVD_BITS-1:0] R_MAX = 32'd16383;
  localparam logic [DIVD_BITS-1:0] B_MAX = 32'd8191;
  localparam logic [DIVD_BITS-1:0] A_MAX = 32'd63;

  // Configuration register indexes
  localparam logic [2:0] REG_REFERENCE = 3'd0;
  localparam logic [2:0] REG_STEP      = 3'd1;
  localparam logic [2:0] REG_PRESC_VAL = 3'd2;
  localparam logic [2:0] REG_PRESC_CODE = 3'd3;
  localparam logic [2:0] REG_MUX       = 3'd4;

  // Reset values of the configuration registers
  localparam logic [26:0] RST_REFERENCE = 27'd10000000;
  localparam logic [26:0] RST_STEP      = 27'd25000;
  localparam logic [6:0]  RST_PRESC_VAL = 7'd8;

  // Register address codes in the low two bits of each word
  localparam logic [1:0] ADDR_R    = 2'h0;
  localparam logic [1:0] ADDR_AB   = 2'h1;
  localparam logic [1:0] ADDR_FUNC = 2'h2;

  // Configuration set
  typedef struct packed {
    logic [26:0] reference_hz;
    logic [26:0] step_hz;
    logic [6:0]  prescaler_value;
    logic [1:0]  prescaler_code;
    logic [2:0]  mux_select;
  } cfg_t;

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIVD_BITS-1:0] dividend;
    logic [DIVS_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIVD_BITS-1:0] quotient;
    logic [DIVS_BITS-1:0] remainder;
  } div_rsp_t;

  // Classified counter set handed from front to back
  typedef struct packed {
    logic [R_BITS-1:0] r;
    logic [B_BITS-1:0] b;
    logic [A_BITS-1:0] a;
    logic              err;
  } counters_t;

  // Front sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_R,
    ST_DIV_N,
    ST_DIV_AB,
    ST_PUSH
  } front_state_t;

  // Word order in one sequence
  typedef enum logic [1:0] {
    WSEL_FUNC_RST,
    WSEL_R,
    WSEL_AB,
    WSEL_FUNC_RUN
  } word_sel_t;

endpackage

// ===== rtl/pdwb_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pdwb_pkg.

module pdwb_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  pdwb_pkg::div_req_t req,
  output pdwb_pkg::div_rsp_t rsp
);

  logic [pdwb_pkg::DIVD_BITS-1:0] quo_r, quo_nxt;
  logic [pdwb_pkg::DIVS_BITS-1:0] rem_r, rem_nxt;
  logic [pdwb_pkg::DIVS_BITS-1:0] div_r;
  logic [pdwb_pkg::CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                           done_r, done_nxt;
  logic [pdwb_pkg::DIVS_BITS:0]   shifted;
  logic [pdwb_pkg::DIVS_BITS+1:0] diff;
  logic                           ge;

  // One shift-subtract step
  always_comb begin
    shifted = {rem_r, quo_r[pdwb_pkg::DIVD_BITS-1]};
    diff    = {1'b0, shifted} - {2'b00, div_r};
    ge      = !diff[pdwb_pkg::DIVS_BITS+1];
  end

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      cnt_nxt = pdwb_pkg::CNT_BITS'(pdwb_pkg::DIVD_BITS);
    end else if (cnt_r != '0) begin
      quo_nxt = {quo_r[pdwb_pkg::DIVD_BITS-2:0], ge};
      rem_nxt = ge ? diff[pdwb_pkg::DIVS_BITS-1:0] : shifted[pdwb_pkg::DIVS_BITS-1:0];
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == pdwb_pkg::CNT_BITS'(1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      div_r <= req.divisor;
    end
  end

  assign rsp.busy      = (cnt_r != '0);
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== rtl/pdwb_front.sv =====
// Front end: accepts target beats, runs R, N and B/A divisions on the
// shared divider, flags range errors and pushes counters into the queue.
// Depends on pdwb_pkg and pdwb_divider.

module pdwb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdwb_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_target_hz,
  output logic                 q_push,
  output pdwb_pkg::counters_t  q_data,
  input  logic                 q_full
);

  pdwb_pkg::front_state_t state_r, state_nxt;
  pdwb_pkg::div_req_t     div_req;
  pdwb_pkg::div_rsp_t     div_rsp;
  pdwb_pkg::counters_t    ent_r, ent_nxt;

  logic [31:0] target_r;
  logic [26:0] r_r, r_nxt;
  logic [31:0] n_r, n_nxt;
  logic        step_zero;
  logic        presc_zero;
  logic [31:0] b_full;
  logic [31:0] a_full;
  logic [31:0] r_full;
  logic        err;

  pdwb_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign step_zero  = (cfg.step_hz == '0);
  assign presc_zero = (cfg.prescaler_value == '0);
  assign in_stall   = (state_r != pdwb_pkg::ST_IDLE);

  // Split N into B and A, classify against field limits
  always_comb begin
    b_full = presc_zero ? '0 : div_rsp.quotient;
    a_full = presc_zero ? n_r : {5'b0, div_rsp.remainder};
    r_full = {5'b0, r_r};
    err    = step_zero || (r_r == '0) || (a_full > b_full) ||
             (r_full > pdwb_pkg::R_MAX) || (b_full > pdwb_pkg::B_MAX) ||
             (a_full > pdwb_pkg::A_MAX);
  end

  // Sequencer: next state, divider requests, result capture
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = {5'b0, cfg.reference_hz};
    div_req.divisor  = cfg.step_hz;
    r_nxt            = r_r;
    n_nxt            = n_r;
    ent_nxt          = ent_r;
    q_push           = 1'b0;
    case (state_r)
      pdwb_pkg::ST_IDLE: begin
        if (in_valid) begin
          div_req.start = 1'b1;
          state_nxt     = pdwb_pkg::ST_DIV_R;
        end
      end
      pdwb_pkg::ST_DIV_R: begin
        if (div_rsp.done) begin
          r_nxt            = step_zero ? '0 : div_rsp.quotient[26:0];
          div_req.start    = 1'b1;
          div_req.dividend = target_r;
          state_nxt        = pdwb_pkg::ST_DIV_N;
        end
      end
      pdwb_pkg::ST_DIV_N: begin
        if (div_rsp.done) begin
          n_nxt            = step_zero ? '0 : div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = n_nxt;
          div_req.divisor  = {20'b0, cfg.prescaler_value};
          state_nxt        = pdwb_pkg::ST_DIV_AB;
        end
      end
      pdwb_pkg::ST_DIV_AB: begin
        if (div_rsp.done) begin
          ent_nxt.r   = (r_full > pdwb_pkg::R_MAX) ? pdwb_pkg::R_MAX[13:0] : r_r[13:0];
          ent_nxt.b   = (b_full > pdwb_pkg::B_MAX) ? pdwb_pkg::B_MAX[12:0] : b_full[12:0];
          ent_nxt.a   = (a_full > pdwb_pkg::A_MAX) ? pdwb_pkg::A_MAX[5:0] : a_full[5:0];
          ent_nxt.err = err;
          state_nxt   = pdwb_pkg::ST_PUSH;
        end
      end
      pdwb_pkg::ST_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = pdwb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pdwb_pkg::ST_IDLE;
      end
    endcase
  end

  assign q_data = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdwb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    n_r   <= n_nxt;
    ent_r <= ent_nxt;
    if (in_valid && !in_stall) begin
      target_r <= in_target_hz;
    end
  end

`ifndef SYNTHESIS
  // A new division never starts on top of a running one
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule

// ===== rtl/pdwb_queue.sv =====
// Two-entry queue between front and back, carrying counter sets.
// Depends on pdwb_pkg.

module pdwb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pdwb_pkg::counters_t push_data,
  output logic                full,
  input  logic                pop,
  output pdwb_pkg::counters_t pop_data,
  output logic                valid
);

  pdwb_pkg::counters_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_data = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("queue pop while empty");
`endif

endmodule

// ===== rtl/pdwb_back.sv =====
// Back end: pops counter sets and emits the four control words through an
// output register. Depends on pdwb_pkg.

module pdwb_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pdwb_pkg::cfg_t                 cfg,
  input  logic                           q_valid,
  input  pdwb_pkg::counters_t            q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pdwb_pkg::WORD_BITS-1:0] out_control_word,
  output logic                           out_last_word,
  output logic                           out_range_error
);

  pdwb_pkg::counters_t ent_r, ent_nxt;
  pdwb_pkg::word_sel_t idx_r, idx_nxt;
  logic                ent_valid_r, ent_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [pdwb_pkg::WORD_BITS-1:0] out_word_r, word;
  logic                out_last_r, out_err_r;
  logic                load_out;
  logic                last_sel;

  // Word for the current index
  always_comb begin
    case (idx_r)
      pdwb_pkg::WSEL_FUNC_RST:
        word = {cfg.prescaler_code, 14'b0, 1'b1, cfg.mux_select, 1'b0, 1'b1,
                pdwb_pkg::ADDR_FUNC};
      pdwb_pkg::WSEL_R:
        word = {8'b0, ent_r.r, pdwb_pkg::ADDR_R};
      pdwb_pkg::WSEL_AB:
        word = {3'b0, ent_r.b, ent_r.a, pdwb_pkg::ADDR_AB};
      pdwb_pkg::WSEL_FUNC_RUN:
        word = {cfg.prescaler_code, 14'b0, 1'b1, cfg.mux_select, 1'b0, 1'b0,
                pdwb_pkg::ADDR_FUNC};
      default:
        word = '0;
    endcase
  end

  // Output register loads when a set is held and it is empty or being taken
  always_comb begin
    last_sel      = (idx_r == pdwb_pkg::WSEL_FUNC_RUN);
    load_out      = ent_valid_r && (!out_valid_r || !out_stall);
    q_pop         = q_valid && (!ent_valid_r || (load_out && last_sel));
    out_valid_nxt = load_out || (out_valid_r && out_stall);
    ent_nxt       = q_pop ? q_data : ent_r;
    ent_valid_nxt = q_pop || (ent_valid_r && !(load_out && last_sel));
    idx_nxt       = idx_r;
    if (q_pop) begin
      idx_nxt = pdwb_pkg::WSEL_FUNC_RST;
    end else if (load_out) begin
      idx_nxt = pdwb_pkg::word_sel_t'(idx_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= pdwb_pkg::WSEL_FUNC_RST;
    end else begin
      ent_valid_r <= ent_valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (load_out) begin
      out_word_r <= word;
      out_last_r <= last_sel;
      out_err_r  <= ent_r.err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_control_word = out_word_r;
  assign out_last_word    = out_last_r;
  assign out_range_error  = out_err_r;

`ifndef SYNTHESIS
  // Closing word is the function word with counter reset clear
  a_last_is_func: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |->
      (out_word_r[1:0] == pdwb_pkg::ADDR_FUNC) && !out_word_r[2])
    else $error("last word is not the running function word");
  // Words of one sequence follow without gaps and share the error flag
  a_seq_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !out_last_r) |=>
      out_valid_r && (out_err_r == $past(out_err_r)))
    else $error("sequence broken or error flag changed");
  // A new set is only taken between sequences
  a_pop_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && ent_valid_r) |-> (idx_r == pdwb_pkg::WSEL_FUNC_RUN))
    else $error("counter set replaced mid-sequence");
`endif

endmodule

// ===== rtl/pll_divider_word_builder.sv =====
// PLL divider word builder, top level: config registers, front, queue, back.
// Depends on pdwb_pkg, pdwb_front, pdwb_queue and pdwb_back.
// The front runs its divisions on an accepted target beat, then the back emits
// four words on consecutive cycles unless stalled. No new target is taken
// until three divisions on the shared radix-2 divider end and the counters are
// pushed. Reset: sync active-low rst_n, default configuration.

module pll_divider_word_builder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_target_hz,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pdwb_pkg::WORD_BITS-1:0] out_control_word,
  output logic                           out_last_word,
  output logic                           out_range_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [26:0]                    cfg_data
);

  pdwb_pkg::cfg_t      cfg_r, cfg_nxt;
  pdwb_pkg::counters_t q_in, q_out;
  logic                q_push, q_full, q_pop, q_valid;

  assign cfg_ready = 1'b1;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pdwb_pkg::REG_REFERENCE:  cfg_nxt.reference_hz    = cfg_data;
        pdwb_pkg::REG_STEP:       cfg_nxt.step_hz         = cfg_data;
        pdwb_pkg::REG_PRESC_VAL:  cfg_nxt.prescaler_value = cfg_data[6:0];
        pdwb_pkg::REG_PRESC_CODE: cfg_nxt.prescaler_code  = cfg_data[1:0];
        pdwb_pkg::REG_MUX:        cfg_nxt.mux_select      = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reference_hz    <= pdwb_pkg::RST_REFERENCE;
      cfg_r.step_hz         <= pdwb_pkg::RST_STEP;
      cfg_r.prescaler_value <= pdwb_pkg::RST_PRESC_VAL;
      cfg_r.prescaler_code  <= 2'd0;
      cfg_r.mux_select      <= 3'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pdwb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_target_hz (in_target_hz),
    .q_push       (q_push),
    .q_data       (q_in),
    .q_full       (q_full)
  );

  pdwb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .valid     (q_valid)
  );

  pdwb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_control_word (out_control_word),
    .out_last_word    (out_last_word),
    .out_range_error  (out_range_error)
  );

endmodule
